@@ src/linear_probe_hash_table_defines.svh @@
// Assertion helpers for the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define LPHT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define LPHT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/lpht_pkg.sv @@
package lpht_pkg;

	localparam int KEY_W  = 31;
	localparam int DATA_W = 32;
	localparam int SLOT_W = 6;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_SEARCH = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	localparam logic [1:0] MARK_EMPTY   = 2'd0;
	localparam logic [1:0] MARK_USED    = 2'd1;
	localparam logic [1:0] MARK_DELETED = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [1:0]               command;
		logic [KEY_W-1:0]         key;
		logic signed [DATA_W-1:0] data_in;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] data_out;
		logic [SLOT_W-1:0]        slot_index;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]         key;
		logic signed [DATA_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic [1:0] mark;
		entry_t     entry;
	} slot_t;

	typedef struct packed {
		logic       mark_we;
		logic       ent_we;
		logic [1:0] mark;
	} wr_ctl_t;

endpackage

@@ src/lpht_home.sv @@
module lpht_home #(
	parameter int DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [lpht_pkg::KEY_W-1:0]      key,
	output logic                            done,
	output logic [$clog2(DEPTH)-1:0]        home
);
	import lpht_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);

	if ((DEPTH & (DEPTH - 1)) == 0) begin : g_mask
		logic             done_q;
		logic [IDX_W-1:0] home_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else begin
				done_q <= start;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				home_q <= key[IDX_W-1:0];
			end
		end

		assign done = done_q;
		assign home = home_q;
	end else begin : g_recip
		localparam int               SH       = KEY_W + IDX_W;
		localparam int               PROD_W   = KEY_W + 32;
		localparam logic [63:0]      RECIP_W  =
			((64'd1 << SH) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);
		localparam logic [31:0]      RECIP    = RECIP_W[31:0];
		localparam logic [IDX_W-1:0] DEPTH_LO = IDX_W'(DEPTH);

		logic              vld_s1;
		logic              done_s2;
		logic [IDX_W-1:0]  quo_s1;
		logic [IDX_W-1:0]  key_lo_s1;
		logic [IDX_W-1:0]  home_s2;
		logic [PROD_W-1:0] prod;

		// The scaled reciprocal gives the exact quotient for every key, so the
		// remainder fits in IDX_W bits and only the low bits are needed.
		assign prod = PROD_W'(key) * PROD_W'(RECIP);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s1  <= 1'b0;
				done_s2 <= 1'b0;
			end else begin
				vld_s1  <= start;
				done_s2 <= vld_s1;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				quo_s1    <= prod[SH +: IDX_W];
				key_lo_s1 <= key[IDX_W-1:0];
			end
			if (vld_s1) begin
				home_s2 <= key_lo_s1 - quo_s1 * DEPTH_LO;
			end
		end

		assign done = done_s2;
		assign home = home_s2;
	end

endmodule

@@ src/lpht_store.sv @@
module lpht_store #(
	parameter int DEPTH = 64
) (
	input  logic                       clk,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output lpht_pkg::slot_t            rd_slot,
	input  lpht_pkg::wr_ctl_t          wr,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  lpht_pkg::entry_t           wr_entry
);
	import lpht_pkg::*;

	logic [1:0] mark_mem [DEPTH];
	entry_t     entry_mem [DEPTH];
	slot_t      rd_slot_q;

	always_ff @(posedge clk) begin
		if (wr.mark_we) begin
			mark_mem[wr_addr] <= wr.mark;
		end
		if (wr.ent_we) begin
			entry_mem[wr_addr] <= wr_entry;
		end
		rd_slot_q.mark  <= mark_mem[rd_addr];
		rd_slot_q.entry <= entry_mem[rd_addr];
	end

	assign rd_slot = rd_slot_q;

endmodule

@@ src/linear_probe_hash_table.sv @@
// Hash table with linear probing and tombstone deletes.
// A request transaction carries a command (insert, search, delete), a key and
// a data word; every request yields exactly one response with a status, the
// stored data word (zero on insert or miss) and the slot number (low six bits).
// Both channels use valid/ready. req_ready is high only while the table is
// idle, so one request is in flight at a time.
// The home slot unit registers the key's low bits when TABLE_DEPTH is a power
// of two; otherwise it reduces the key by a reciprocal multiplication, with the
// quotient and the remainder in separate register stages. The probe loop then
// reads one slot per cycle from the slot memory, which has a registered read.
// A command outside insert, search and delete probes no slot and goes straight
// from the hash step to the response.
// After reset the slot marks are cleared one per cycle; req_ready stays low
// until every mark is cleared.
// The response sits in an output register. If the receiver stalls, a
// finished request waits in the table until that register is free, and no
// new request is taken meanwhile.
`include "linear_probe_hash_table_defines.svh"

module linear_probe_hash_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  lpht_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output lpht_pkg::rsp_t  rsp
);
	import lpht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_HASH  = 3'd2;
	localparam logic [2:0] S_PROBE = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;

	logic [2:0]            state_q;
	logic [IDX_W-1:0]      clr_q;
	logic                  chk_vld_q;
	logic                  rsp_valid_q;
	logic [1:0]            cmd_q;
	logic [KEY_W-1:0]      key_q;
	logic [DATA_W-1:0]     data_q;
	logic [IDX_W-1:0]      addr_q;
	logic [IDX_W-1:0]      chk_addr_q;
	logic [IDX_W-1:0]      cnt_q;
	rsp_t                  res_q;
	rsp_t                  rsp_q;

	logic                  accept;
	logic                  home_done;
	logic [IDX_W-1:0]      home;
	slot_t                 rd_slot;
	wr_ctl_t               wr;
	logic [IDX_W-1:0]      wr_addr;
	entry_t                wr_entry;
	logic                  hit;
	logic                  miss;
	logic                  load_rsp;
	logic [IDX_W+SLOT_W-1:0] slot_wide;
	logic [SLOT_W-1:0]     slot_num;

	assign req_ready = (state_q == S_IDLE);
	assign accept    = req_valid && req_ready;
	assign load_rsp  = (state_q == S_EMIT) && (!rsp_valid_q || rsp_ready);
	assign slot_wide = {{SLOT_W{1'b0}}, chk_addr_q};
	assign slot_num  = slot_wide[SLOT_W-1:0];
	assign wr_entry  = '{key: key_q, value: data_q};

	lpht_home #(
		.DEPTH(TABLE_DEPTH)
	) u_home (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.key   (req.key),
		.done  (home_done),
		.home  (home)
	);

	lpht_store #(
		.DEPTH(TABLE_DEPTH)
	) u_store (
		.clk     (clk),
		.rd_addr (addr_q),
		.rd_slot (rd_slot),
		.wr      (wr),
		.wr_addr (wr_addr),
		.wr_entry(wr_entry)
	);

	always_comb begin
		wr      = '0;
		wr_addr = chk_addr_q;
		hit     = 1'b0;
		miss    = 1'b0;
		if (state_q == S_CLEAR) begin
			wr.mark_we = 1'b1;
			wr.mark    = MARK_EMPTY;
			wr_addr    = clr_q;
		end else if (state_q == S_PROBE && chk_vld_q) begin
			if (cmd_q == CMD_INSERT) begin
				if (rd_slot.mark != MARK_USED) begin
					wr.mark_we = 1'b1;
					wr.ent_we  = 1'b1;
					wr.mark    = MARK_USED;
					hit        = 1'b1;
				end
			end else if (rd_slot.mark == MARK_EMPTY) begin
				miss = 1'b1;
			end else if (rd_slot.mark == MARK_USED && rd_slot.entry.key == key_q) begin
				hit = 1'b1;
				if (cmd_q == CMD_DELETE) begin
					wr.mark_we = 1'b1;
					wr.mark    = MARK_DELETED;
				end
			end
			if (!hit && !miss && cnt_q == LAST_IDX) begin
				miss = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			chk_vld_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					chk_vld_q <= 1'b0;
					if (home_done) begin
						if (cmd_q inside {CMD_INSERT, CMD_SEARCH, CMD_DELETE}) begin
							state_q <= S_PROBE;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_PROBE: begin
					chk_vld_q <= 1'b1;
					if (hit || miss) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load_rsp) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.command;
			key_q  <= req.key;
			data_q <= req.data_in;
		end
		if (state_q == S_HASH) begin
			addr_q <= home;
			cnt_q  <= '0;
			res_q  <= '{status: ST_NOT_FOUND, data_out: '0, slot_index: '0};
		end
		if (state_q == S_PROBE) begin
			addr_q     <= (addr_q == LAST_IDX) ? '0 : addr_q + 1'b1;
			chk_addr_q <= addr_q;
			if (chk_vld_q) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (hit) begin
				res_q.status     <= ST_OK;
				res_q.data_out   <= (cmd_q == CMD_INSERT) ? '0 : rd_slot.entry.value;
				res_q.slot_index <= slot_num;
			end else if (miss) begin
				res_q.status     <= (cmd_q == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
				res_q.data_out   <= '0;
				res_q.slot_index <= '0;
			end
		end
		if (load_rsp) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`LPHT_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")
	`LPHT_ASSERT_SAME(a_entry_write_used, wr.ent_we, wr.mark_we && wr.mark == MARK_USED, "entry write without used mark")
	`LPHT_ASSERT_SAME(a_mark_write_phase, wr.mark_we, state_q == S_CLEAR || (state_q == S_PROBE && chk_vld_q), "mark write outside clear or probe")
	`LPHT_ASSERT_NEXT(a_emit_loads, load_rsp, rsp_valid && state_q == S_IDLE, "response not loaded")

endmodule
